// ===== rtl/wnh_pkg.sv =====
// wnh_pkg: shared constants, types and the sine table builder for the harmonic NCO
package wnh_pkg;

  // table geometry and sample format
  localparam int unsigned TABLE_SIZE  = 4096;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned ADDR_W      = $clog2(TABLE_SIZE);
  localparam int unsigned PROD_W      = 32 + ADDR_W;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned PHASE_W     = 32;

  // configuration port
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_STEP   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_INTERPOLATE = CFG_IDX_W'(1);

  // fixed point constants for the table build
  localparam logic [63:0] TWO_PI_Q40  = 64'd6908435304715;
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] AMPLITUDE   = 64'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
  localparam logic [63:0] THETA_BIAS  = 64'(TABLE_SIZE) * 64'd2048;
  localparam logic [63:0] THETA_DIV   = 64'(TABLE_SIZE) * 64'd4096;
  localparam int unsigned ROM_BLOCKS  = (TABLE_SIZE + 63) / 64;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [TABLE_SIZE-1:0][SAMPLE_BITS-1:0] rom_t;

  // per-lane control from the top level
  typedef struct packed {
    logic load;
    logic interp;
  } lane_ctrl_t;

  // one table entry: quadrant fold, then a 13th-order Taylor sine in Q30
  function automatic sample_t rom_entry(input int unsigned i);
    logic [63:0] m;
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] theta;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] s;
    logic [63:0] v;
    logic [63:0] res;
    m = 64'(i) * 64'd4;
    quad = m / TABLE_SIZE;
    r = m % TABLE_SIZE;
    if (quad[0]) begin
      r = 64'(TABLE_SIZE) - r;
    end
    theta = (r * TWO_PI_Q40 + THETA_BIAS) / THETA_DIV;
    x2 = (theta * theta) >> 30;
    acc = Q30_ONE;
    acc = Q30_ONE - ((x2 * acc) >> 30) / 156;
    acc = Q30_ONE - ((x2 * acc) >> 30) / 110;
    acc = Q30_ONE - ((x2 * acc) >> 30) / 72;
    acc = Q30_ONE - ((x2 * acc) >> 30) / 42;
    acc = Q30_ONE - ((x2 * acc) >> 30) / 20;
    acc = Q30_ONE - ((x2 * acc) >> 30) / 6;
    s = (theta * acc) >> 30;
    v = (s * AMPLITUDE + (64'd1 << 29)) >> 30;
    if (v > AMPLITUDE) begin
      v = AMPLITUDE;
    end
    res = (quad >= 64'd2) ? (64'd0 - v) : v;
    return res[SAMPLE_BITS-1:0];
  endfunction

  // whole period, built at elaboration
  function automatic rom_t build_rom();
    rom_t t;
    int unsigned idx;
    t = '0;
    for (int unsigned hi = 0; hi < ROM_BLOCKS; hi++) begin
      for (int unsigned lo = 0; lo < 64; lo++) begin
        idx = hi * 64 + lo;
        if (idx < TABLE_SIZE) begin
          t[idx] = rom_entry(idx);
        end
      end
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

endpackage

// ===== rtl/wavetable_nco_harmonics_core.sv =====
// wavetable_nco_harmonics_core: phase accumulator nco with harmonic and quadrature sine outputs
//
//   channel  | signals                                  | dir | request
//   ---------+------------------------------------------+-----+---------------------------
//   cfg      | cfg_valid cfg_ready cfg_index cfg_data   | in  | one register write
//   in       | in_valid in_ready offset_step            | in  | one sample tick
//   out      | out_valid out_ready sine_out             | out | one set of five samples
//            | sine_double_out sine_triple_out          |     |
//            | quad_real_out quad_imag_out              |     |
//
// one request per cycle unless the output stalls; a tick passes through stages 1, 2 and 3
// phase_acc updates from a combinational sum; five lanes each read the rom at two addresses
// reset clears phase, base step, interpolate and all valid flags; the rom is fixed at build
// a stalled output holds full stages up to a bubble; in_ready drops only when all are full
// cfg_ready is always high; writing base_step also clears the phase
module wavetable_nco_harmonics_core
  import wnh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   offset_step,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   sine_out,
  output logic signed [15:0]   sine_double_out,
  output logic signed [15:0]   sine_triple_out,
  output logic signed [15:0]   quad_real_out,
  output logic signed [15:0]   quad_imag_out
);

  localparam int unsigned LANES = 5;

  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] base_step;
  logic               interpolate;
  logic [PHASE_W+2:0] phase_sum;

  logic [PHASE_W-1:0] p1;
  logic               v1;
  logic               v2;
  logic               en1;
  logic               en2;
  logic               en3;
  logic               in_fire;
  logic               cfg_fire;

  logic [PHASE_W-1:0] lane_phase [LANES];
  logic [OUT_W-1:0]   lane_sample [LANES];
  lane_ctrl_t         lane_ctrl;

  // pipeline advance, from the output back
  assign en3      = !out_valid || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign in_fire  = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // phase update: clamp at zero when the sum goes negative, else wrap
  always_comb begin
    phase_sum  = {3'b000, phase_acc} + {3'b000, base_step}
               + {{3{offset_step[31]}}, offset_step};
    phase_next = phase_sum[PHASE_W+2] ? '0 : phase_sum[PHASE_W-1:0];
  end

  // configuration registers and phase accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      base_step   <= '0;
      interpolate <= 1'b0;
      phase_acc   <= '0;
    end else begin
      if (cfg_fire && cfg_index == REG_INTERPOLATE) begin
        interpolate <= cfg_data[0];
      end
      if (cfg_fire && cfg_index == REG_BASE_STEP) begin
        base_step <= cfg_data;
        phase_acc <= '0;
      end else if (in_fire) begin
        phase_acc <= phase_next;
      end
    end
  end

  // stage 1: new phase
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1 <= phase_next;
    end
  end

  // derived phases for the five lanes
  always_comb begin
    lane_phase[0] = p1;
    lane_phase[1] = {p1[PHASE_W-2:0], 1'b0};
    lane_phase[2] = p1 + {p1[PHASE_W-2:0], 1'b0};
    lane_phase[3] = p1 + 32'h8000_0000;
    lane_phase[4] = p1 + 32'h4000_0000;
  end

  assign lane_ctrl.load   = en2;
  assign lane_ctrl.interp = interpolate;

  // stage 2: rom lanes
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    wnh_lane u_lane (
      .clk    (clk),
      .ctrl   (lane_ctrl),
      .phase  (lane_phase[g]),
      .sample (lane_sample[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  // stage 3: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en3) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      sine_out        <= lane_sample[0];
      sine_double_out <= lane_sample[1];
      sine_triple_out <= lane_sample[2];
      quad_real_out   <= lane_sample[3];
      quad_imag_out   <= lane_sample[4];
    end
  end

  // base step write restarts the phase
  a_base_clears_phase: assert property (@(posedge clk) disable iff (rst)
    cfg_fire && cfg_index == REG_BASE_STEP |=> phase_acc == '0)
    else $error("phase not cleared after base step write");

  // a blocked stage 1 keeps its phase
  a_stage1_holds: assert property (@(posedge clk) disable iff (rst)
    v1 && !en2 |=> v1 && $stable(p1))
    else $error("stage 1 lost its phase under stall");

  // full pipeline with a stalled output takes no new tick
  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline full");

  // a taken tick always lands in stage 1
  a_tick_enters: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> v1 && p1 == $past(phase_next))
    else $error("accepted tick missing from stage 1");

endmodule

// ===== rtl/wnh_lane.sv =====
// wnh_lane: table address, registered two-entry rom read and linear interpolation
module wnh_lane
  import wnh_pkg::*;
(
  input  logic               clk,
  input  lane_ctrl_t         ctrl,
  input  logic [PHASE_W-1:0] phase,
  output logic [OUT_W-1:0]   sample
);

  localparam int unsigned DIFF_W = SAMPLE_BITS + 1;
  localparam int unsigned MUL_W  = SAMPLE_BITS + 18;

  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] nxt;
  logic [15:0]       frac;

  sample_t           ent_a;
  sample_t           ent_b;
  logic [15:0]       frac_q;
  logic              interp_q;

  logic signed [DIFF_W-1:0] diff;
  logic signed [MUL_W-1:0]  scaled;
  logic signed [MUL_W-1:0]  rounded;
  logic signed [MUL_W-1:0]  blend;
  logic signed [MUL_W-1:0]  base_ext;

  // phase times table size: integer part is the index, next 16 bits the fraction
  assign prod = PROD_W'(phase) * PROD_W'(TABLE_SIZE);
  assign idx  = prod[PROD_W-1:PHASE_W];
  assign frac = prod[PHASE_W-1:PHASE_W-16];
  assign nxt  = (idx == ADDR_W'(TABLE_SIZE - 1)) ? '0 : idx + 1'b1;

  // rom read, registered
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      ent_a    <= SINE_ROM[idx];
      ent_b    <= SINE_ROM[nxt];
      frac_q   <= frac;
      interp_q <= ctrl.interp;
    end
  end

  // a + floor(((b - a) * frac + half) / 2^16)
  always_comb begin
    diff     = DIFF_W'(ent_b) - DIFF_W'(ent_a);
    scaled   = MUL_W'(diff) * MUL_W'($signed({1'b0, frac_q}));
    rounded  = scaled + MUL_W'(32768);
    base_ext = MUL_W'(ent_a);
    blend    = base_ext + (rounded >>> 16);
  end

  assign sample = interp_q ? blend[OUT_W-1:0] : base_ext[OUT_W-1:0];

endmodule

// ===== bench/wavetable_nco_harmonics_core_tb.sv =====
// self-checking testbench for the harmonic nco core: directed corners, then randomized phases
`timescale 1ns / 100ps

module wavetable_nco_harmonics_core_tb;
  import wnh_pkg::*;

  // register indexes that map to nothing
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_TOP = '1;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned TICKS_PER_PHASE = 200;

  typedef logic signed [OUT_W-1:0] level_t;

  // one expected set of five samples
  typedef struct {
    level_t sine;
    level_t sine_double;
    level_t sine_triple;
    level_t quad_real;
    level_t quad_imag;
  } tone_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [31:0]   offset_step = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [15:0]   sine_out;
  logic signed [15:0]   sine_double_out;
  logic signed [15:0]   sine_triple_out;
  logic signed [15:0]   quad_real_out;
  logic signed [15:0]   quad_imag_out;

  // predictor state
  longint      sine_table [TABLE_SIZE];
  bit [31:0]   model_phase;
  bit [31:0]   model_base;
  bit          model_interp;
  tone_t       pending_tones [$];
  int          fail_count;
  int unsigned gap_max;
  int unsigned stall_max;
  int unsigned hold_cycles;

  wavetable_nco_harmonics_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .offset_step     (offset_step),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .sine_out        (sine_out),
    .sine_double_out (sine_double_out),
    .sine_triple_out (sine_triple_out),
    .quad_real_out   (quad_real_out),
    .quad_imag_out   (quad_imag_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one table entry: fold to first quadrant, taylor sine in q30, scale and round
  function automatic longint sine_entry(int unsigned i);
    longint unsigned n;
    longint unsigned turns4;
    longint unsigned quadrant;
    longint unsigned rem;
    longint unsigned theta;
    longint unsigned x2;
    longint unsigned poly;
    longint unsigned s;
    longint unsigned mag;
    longint unsigned amp;
    longint unsigned horner_div [6];
    horner_div = '{156, 110, 72, 42, 20, 6};
    n = TABLE_SIZE;
    amp = (64'd1 << (SAMPLE_BITS - 1)) - 1;
    turns4 = longint'(i) * 4;
    quadrant = turns4 / n;
    rem = turns4 % n;
    if (quadrant[0]) begin
      rem = n - rem;
    end
    theta = (rem * 64'd6908435304715 + n * 2048) / (n * 4096);
    x2 = (theta * theta) >> 30;
    poly = 64'd1 << 30;
    for (int k = 0; k < 6; k++) begin
      poly = (64'd1 << 30) - ((x2 * poly) >> 30) / horner_div[k];
    end
    s = (theta * poly) >> 30;
    mag = (s * amp + (64'd1 << 29)) >> 30;
    if (mag > amp) begin
      mag = amp;
    end
    return (quadrant >= 2) ? -longint'(mag) : longint'(mag);
  endfunction

  // table read at a phase, nearest lower entry or linear blend
  function automatic level_t table_read(bit [31:0] q);
    longint unsigned prod;
    int unsigned     idx;
    int unsigned     nxt;
    longint          a;
    longint          b;
    longint          f;
    prod = longint'(q) * longint'(TABLE_SIZE);
    idx = int'(prod >> 32);
    if (idx >= TABLE_SIZE) begin
      idx = 0;
    end
    a = sine_table[idx];
    if (!model_interp) begin
      return level_t'(a);
    end
    nxt = (idx + 1 >= TABLE_SIZE) ? 0 : idx + 1;
    b = sine_table[nxt];
    f = longint'((prod >> 16) & 64'hFFFF);
    return level_t'(a + (((b - a) * f + 32768) >>> 16));
  endfunction

  // advance the phase for one tick and queue the five samples it produces
  function automatic void predict_tone(logic signed [31:0] off);
    longint    sum;
    bit [31:0] p;
    bit [31:0] p2;
    bit [31:0] p3;
    bit [31:0] p_half;
    bit [31:0] p_quarter;
    tone_t     t;
    sum = longint'(model_phase) + longint'(model_base) + longint'(off);
    model_phase = (sum < 0) ? 32'd0 : sum[31:0];
    p = model_phase;
    p2 = p * 2;
    p3 = p * 3;
    p_half = p + 32'h8000_0000;
    p_quarter = p + 32'h4000_0000;
    t.sine = table_read(p);
    t.sine_double = table_read(p2);
    t.sine_triple = table_read(p3);
    t.quad_real = table_read(p_half);
    t.quad_imag = table_read(p_quarter);
    pending_tones.insert(pending_tones.size(), t);
  endfunction

  function automatic void compare_level(string field, level_t want, level_t got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_tone();
    tone_t want;
    if (pending_tones.size() == 0) begin
      $error("result with nothing expected: sine_out %0d", sine_out);
      fail_count++;
    end else begin
      want = pending_tones.pop_front();
      compare_level("sine_out", want.sine, sine_out);
      compare_level("sine_double_out", want.sine_double, sine_double_out);
      compare_level("sine_triple_out", want.sine_triple, sine_triple_out);
      compare_level("quad_real_out", want.quad_real, quad_real_out);
      compare_level("quad_imag_out", want.quad_imag, quad_imag_out);
    end
  endtask

  // result sink: random stall after every accepted result
  always @(posedge clk) begin : result_sink
    int unsigned draw;
    if (rst) begin
      out_ready <= 1'b0;
      hold_cycles <= 0;
    end else if (out_ready && out_valid) begin
      check_tone();
      draw = $urandom_range(0, stall_max);
      out_ready <= (draw == 0);
      hold_cycles <= draw;
    end else if (!out_ready) begin
      if (hold_cycles <= 1) begin
        out_ready <= 1'b1;
        hold_cycles <= 0;
      end else begin
        hold_cycles <= hold_cycles - 1;
      end
    end
  end

  // send one tick request after a random gap
  task automatic send_tick(logic signed [31:0] off);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    offset_step <= off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_tone(off);
  endtask

  // register write request, mirrored into the predictor
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BASE_STEP: begin
        model_base = data;
        model_phase = '0;
      end
      REG_INTERPOLATE: begin
        model_interp = data[0];
      end
      default: begin
      end
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain every pending result, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_tones.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // reset values: clamp on negative sums, wrap past one turn, field extremes
  task automatic test_wrap_and_clamp();
    gap_max = 9;
    stall_max = 9;
    send_tick(32'sd0);
    send_tick(-32'sd1);
    send_tick(32'sh7FFF_FFFF);
    send_tick(32'sh7FFF_FFFF);
    send_tick(32'sd1);
    send_tick(32'sd1);
    send_tick(32'sh8000_0000);
    send_tick(32'sh4000_0000);
    send_tick(32'sh1555_5555);
  endtask

  // writes: ignored indexes, wide data, phase clear, interpolation at the table end
  task automatic test_register_writes();
    wait_idle();
    write_register(REG_INTERPOLATE, 32'hFFFF_FFFE);
    write_register(REG_UNMAPPED_LOW, 32'h0000_007B);
    write_register(REG_UNMAPPED_TOP, 32'hFFFF_FFFF);
    write_register(REG_BASE_STEP, 32'hFFFF_FFFF);
    send_tick(32'sd0);
    send_tick(32'sh7FFF_FFFF);
    wait_idle();
    write_register(REG_INTERPOLATE, 32'h0000_0001);
    send_tick(32'sd0);
    send_tick(32'sh8000_0000);
    send_tick(32'sh0008_0000);
    wait_idle();
    write_register(REG_BASE_STEP, 32'h0010_0001);
    repeat (5) send_tick(32'sd0);
    send_tick(-32'sd12345);
    send_tick(32'sh8000_0000);
    wait_idle();
    write_register(REG_BASE_STEP, 32'h0000_0000);
    write_register(REG_INTERPOLATE, 32'h0000_0000);
    send_tick(32'sh0000_FFFF);
  endtask

  // offset draw: full range, small steps, extremes, landing near zero, pure carrier
  function automatic logic signed [31:0] draw_offset();
    longint target;
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3, 4: return $urandom_range(0, 131072) - 65536;
      5: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return -32'sd1;
          3: return 32'sd1;
          default: return 32'sd0;
        endcase
      end
      6, 7: begin
        target = -(longint'(model_phase) + longint'(model_base))
                 + longint'($urandom_range(0, 4)) - 2;
        return target[31:0];
      end
      default: return 32'sd0;
    endcase
  endfunction

  // several register settings, cycling through four gap and stall patterns
  task automatic test_random_phases();
    bit [31:0] step;
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: step = 32'h0000_0000;
        1: step = 32'hFFFF_FFFF;
        2: step = $urandom_range(1, 1 << 20);
        4: step = 32'h8000_0000;
        5: step = 32'h4000_0000 + $urandom_range(0, 255);
        default: step = $urandom();
      endcase
      write_register(REG_BASE_STEP, step);
      write_register(REG_INTERPOLATE, ($urandom() & 32'hFFFF_FFFE) | 32'(ph[0]));
      gap_max = (ph % 4 == 0 || ph % 4 == 3) ? 9 : 0;
      stall_max = (ph % 4 == 0 || ph % 4 == 2) ? 9 : 0;
      repeat (TICKS_PER_PHASE) send_tick(draw_offset());
    end
  endtask

  initial begin
    fail_count = 0;
    gap_max = 9;
    stall_max = 9;
    model_phase = '0;
    model_base = '0;
    model_interp = 1'b0;
    for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
      sine_table[i] = sine_entry(i);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_wrap_and_clamp();
    test_register_writes();
    test_random_phases();
    gap_max = 9;
    stall_max = 9;
    wait_idle();
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wnh_pkg.sv
rtl/wnh_lane.sv
rtl/wavetable_nco_harmonics_core.sv
bench/wavetable_nco_harmonics_core_tb.sv
